[rtl/mbe_pkg.sv]
package mbe_pkg;

	localparam int MAX_DIM   = 4096;
	localparam int FRAC_BITS = 56;

	localparam int VAL_W     = 64;
	localparam int CNT_W     = 16;
	localparam int CFG_IDX_W = 3;

	// pixel coordinate mapping
	localparam int PIX_W   = $clog2(MAX_DIM);
	localparam int DIM_W   = PIX_W + 1;
	localparam int OFF_W   = DIM_W + 1;
	localparam int OMAG_W  = OFF_W - 1;
	localparam int SCALE_W = VAL_W - 1;
	localparam int SLO_W   = 32;
	localparam int SHI_W   = SCALE_W - SLO_W;
	localparam int MAP_W   = OMAG_W + SCALE_W;

	// iteration datapath: magnitudes up to two are split into two halves
	localparam int MAG_W  = FRAC_BITS + 2;
	localparam int HALF_W = (MAG_W + 1) / 2;
	localparam int HI_W   = MAG_W - HALF_W;
	localparam int PROD_W = 2 * MAG_W;
	localparam int DIFF_W = (PROD_W + 1 > VAL_W) ? PROD_W + 1 : VAL_W;

	localparam int FIFO_DEPTH = 2;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);

	localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

	// two in fixed point, and four in the squared domain
	localparam logic [VAL_W:0]  ESC_LIN = (VAL_W+1)'(1) << (FRAC_BITS + 1);
	localparam logic [PROD_W:0] ESC_SQ  = (PROD_W+1)'(1) << (2 * FRAC_BITS + 2);

	localparam logic [CNT_W-1:0] MAX_ITER_RST = CNT_W'(256);
	localparam logic [DIM_W-1:0] DIM_RST      = DIM_W'(1024);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CENTER_RE,
		REG_CENTER_IM,
		REG_PIXEL_SCALE,
		REG_MAX_ITER,
		REG_IMAGE_WIDTH,
		REG_IMAGE_HEIGHT,
		REG_ESCAPE_MODE
	} cfg_reg_t;

	typedef enum logic {
		ESC_CIRCLE,
		ESC_DIAMOND
	} esc_mode_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] center_re;
		logic signed [VAL_W-1:0] center_im;
		logic [SCALE_W-1:0]      pixel_scale;
		logic [CNT_W-1:0]        max_iter;
		logic [DIM_W-1:0]        image_width;
		logic [DIM_W-1:0]        image_height;
		esc_mode_t               escape_mode;
	} cfg_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] c_re;
		logic signed [VAL_W-1:0] c_im;
	} point_t;

	typedef enum logic [1:0] {
		FR_IDLE,
		FR_MUL,
		FR_SUM,
		FR_ADD
	} fr_state_t;

	typedef enum logic [2:0] {
		IT_IDLE,
		IT_MAG,
		IT_MUL,
		IT_SUM,
		IT_TEST,
		IT_ADD
	} it_state_t;

	function automatic logic signed [VAL_W-1:0] sat_add(
		input logic signed [VAL_W-1:0] a,
		input logic signed [VAL_W-1:0] b
	);
		logic signed [VAL_W-1:0] s;
		s = a + b;
		if (a[VAL_W-1] == b[VAL_W-1] && s[VAL_W-1] != a[VAL_W-1]) begin
			s = a[VAL_W-1] ? VAL_MIN : VAL_MAX;
		end
		return s;
	endfunction

endpackage

[rtl/mbe_if.sv]
interface mbe_pix_if import mbe_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_x;
	logic [PIX_W-1:0] pixel_y;

	modport source (output valid, output pixel_x, output pixel_y, input ready);
	modport sink (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface mbe_depth_if import mbe_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CNT_W-1:0] depth;

	modport source (output valid, output depth, input ready);
	modport sink (input valid, input depth, output ready);
endinterface

interface mbe_cfg_if import mbe_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [VAL_W-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/mbe_front.sv]
module mbe_front import mbe_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  cfg_t   cfg_regs,
	mbe_pix_if.sink pixel,
	output logic   push_valid,
	input  logic   push_ready,
	output point_t push_data
);

	fr_state_t state_q, state_d;

	logic signed [OFF_W-1:0]   off_x, off_y;
	logic                      neg_x_q, neg_y_q;
	logic [OMAG_W-1:0]         mag_x_q, mag_y_q;
	logic [OMAG_W+SLO_W-1:0]   plo_x_q, plo_y_q;
	logic [OMAG_W+SHI_W-1:0]   phi_x_q, phi_y_q;
	logic [MAP_W-1:0]          prod_x, prod_y;
	logic signed [VAL_W-1:0]   map_re_q, map_im_q;

	function automatic logic [OMAG_W-1:0] off_mag(input logic signed [OFF_W-1:0] o);
		logic [OFF_W-1:0] m;
		m = o[OFF_W-1] ? -o : o;
		return m[OMAG_W-1:0];
	endfunction

	// offset times scale, saturated to the signed range
	function automatic logic signed [VAL_W-1:0] sat_map(
		input logic             neg,
		input logic [MAP_W-1:0] p
	);
		logic signed [VAL_W-1:0] r;
		if (|p[MAP_W-1:VAL_W-1]) begin
			r = neg ? VAL_MIN : VAL_MAX;
		end else begin
			r = neg ? -$signed(p[VAL_W-1:0]) : $signed(p[VAL_W-1:0]);
		end
		return r;
	endfunction

	assign off_x = $signed({1'b0, pixel.pixel_x, 1'b0} - {1'b0, cfg_regs.image_width});
	assign off_y = $signed({1'b0, pixel.pixel_y, 1'b0} - {1'b0, cfg_regs.image_height});

	assign prod_x = (MAP_W'(phi_x_q) << SLO_W) + MAP_W'(plo_x_q);
	assign prod_y = (MAP_W'(phi_y_q) << SLO_W) + MAP_W'(plo_y_q);

	assign push_data.c_re = sat_add(map_re_q, cfg_regs.center_re);
	assign push_data.c_im = sat_add(map_im_q, cfg_regs.center_im);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FR_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			FR_IDLE: begin
				if (pixel.valid) begin
					neg_x_q <= off_x[OFF_W-1];
					neg_y_q <= off_y[OFF_W-1];
					mag_x_q <= off_mag(off_x);
					mag_y_q <= off_mag(off_y);
				end
			end
			FR_MUL: begin
				plo_x_q <= mag_x_q * cfg_regs.pixel_scale[SLO_W-1:0];
				plo_y_q <= mag_y_q * cfg_regs.pixel_scale[SLO_W-1:0];
				phi_x_q <= mag_x_q * cfg_regs.pixel_scale[SCALE_W-1:SLO_W];
				phi_y_q <= mag_y_q * cfg_regs.pixel_scale[SCALE_W-1:SLO_W];
			end
			FR_SUM: begin
				map_re_q <= sat_map(neg_x_q, prod_x);
				map_im_q <= sat_map(neg_y_q, prod_y);
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d     = state_q;
		pixel.ready = 1'b0;
		push_valid  = 1'b0;
		case (state_q)
			FR_IDLE: begin
				pixel.ready = 1'b1;
				if (pixel.valid) begin
					state_d = FR_MUL;
				end
			end
			FR_MUL: begin
				state_d = FR_SUM;
			end
			FR_SUM: begin
				state_d = FR_ADD;
			end
			FR_ADD: begin
				push_valid = 1'b1;
				if (push_ready) begin
					state_d = FR_IDLE;
				end
			end
			default: begin
				state_d = FR_IDLE;
			end
		endcase
	end

endmodule

[rtl/mbe_fifo.sv]
module mbe_fifo import mbe_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push_valid,
	output logic   push_ready,
	input  point_t push_data,
	output logic   pop_valid,
	input  logic   pop_ready,
	output point_t pop_data
);

	point_t           mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]   cnt_q;
	logic             do_push, do_pop;

	assign push_ready = cnt_q != (PTR_W+1)'(FIFO_DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= PTR_W'(wr_ptr_q + 1'b1);
			end
			if (do_pop) begin
				rd_ptr_q <= PTR_W'(rd_ptr_q + 1'b1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

[rtl/mbe_iter.sv]
module mbe_iter import mbe_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg_regs,
	input  logic             pop_valid,
	output logic             pop_ready,
	input  point_t           pop_data,
	output logic             done_valid,
	input  logic             done_ready,
	output logic [CNT_W-1:0] done_depth
);

	it_state_t state_q, state_d;

	logic signed [VAL_W-1:0] c_re_q, c_im_q, z_re_q, z_im_q;
	logic signed [VAL_W-1:0] nr_q, ni_q;
	logic [CNT_W-1:0]        count_q, lim_q;
	logic [MAG_W-1:0]        mr_q, mi_q;
	logic                    neg_q, esc_pre_q;

	logic [2*HI_W-1:0]         rhh_q, ihh_q, xhh_q;
	logic [HI_W+HALF_W-1:0]    rhl_q, ihl_q, xhl_q, xlh_q;
	logic [2*HALF_W-1:0]       rll_q, ill_q, xll_q;
	logic [PROD_W-1:0]         sq_r_q, sq_i_q, cr_q;

	logic [VAL_W-1:0]        mr_full, mi_full;
	logic                    big, dia;
	logic [HI_W-1:0]         r_hi, i_hi;
	logic [HALF_W-1:0]       r_lo, i_lo;
	logic [PROD_W:0]         sq_sum;
	logic signed [DIFF_W-1:0] diff, diff_sh, xs, xs_sh;
	logic                    esc, fin;

	// magnitudes; a step only runs when both are at most two
	always_comb begin
		mr_full = z_re_q[VAL_W-1] ? -z_re_q : z_re_q;
		mi_full = z_im_q[VAL_W-1] ? -z_im_q : z_im_q;
		big     = ({1'b0, mr_full} > ESC_LIN) || ({1'b0, mi_full} > ESC_LIN);
		dia     = ({1'b0, mr_full} + {1'b0, mi_full}) > ESC_LIN;
	end

	assign r_hi = mr_q[MAG_W-1:HALF_W];
	assign r_lo = mr_q[HALF_W-1:0];
	assign i_hi = mi_q[MAG_W-1:HALF_W];
	assign i_lo = mi_q[HALF_W-1:0];

	always_comb begin
		sq_sum  = {1'b0, sq_r_q} + {1'b0, sq_i_q};
		esc     = esc_pre_q || (cfg_regs.escape_mode == ESC_CIRCLE && sq_sum > ESC_SQ);
		fin     = esc || (count_q >= lim_q);
		diff    = DIFF_W'(sq_r_q) - DIFF_W'(sq_i_q);
		diff_sh = diff >>> FRAC_BITS;
		xs      = DIFF_W'(cr_q);
		if (neg_q) begin
			xs = -xs;
		end
		// doubling folded into the shift
		xs_sh   = xs >>> (FRAC_BITS - 1);
	end

	assign done_depth = (count_q == lim_q) ? '0 : count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IT_IDLE;
			count_q <= '0;
			lim_q   <= MAX_ITER_RST;
		end else begin
			state_q <= state_d;
			if (state_q == IT_IDLE && pop_valid) begin
				count_q <= CNT_W'(1);
				lim_q   <= (cfg_regs.max_iter == '0) ? CNT_W'(1) : cfg_regs.max_iter;
			end else if (state_q == IT_TEST && !fin) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			IT_IDLE: begin
				if (pop_valid) begin
					c_re_q <= pop_data.c_re;
					c_im_q <= pop_data.c_im;
					z_re_q <= pop_data.c_re;
					z_im_q <= pop_data.c_im;
				end
			end
			IT_MAG: begin
				mr_q      <= mr_full[MAG_W-1:0];
				mi_q      <= mi_full[MAG_W-1:0];
				neg_q     <= z_re_q[VAL_W-1] ^ z_im_q[VAL_W-1];
				esc_pre_q <= (cfg_regs.escape_mode == ESC_DIAMOND) ? dia : big;
			end
			IT_MUL: begin
				rhh_q <= r_hi * r_hi;
				rhl_q <= r_hi * r_lo;
				rll_q <= r_lo * r_lo;
				ihh_q <= i_hi * i_hi;
				ihl_q <= i_hi * i_lo;
				ill_q <= i_lo * i_lo;
				xhh_q <= r_hi * i_hi;
				xhl_q <= r_hi * i_lo;
				xlh_q <= r_lo * i_hi;
				xll_q <= r_lo * i_lo;
			end
			IT_SUM: begin
				sq_r_q <= (PROD_W'(rhh_q) << (2 * HALF_W)) + (PROD_W'(rhl_q) << (HALF_W + 1))
					+ PROD_W'(rll_q);
				sq_i_q <= (PROD_W'(ihh_q) << (2 * HALF_W)) + (PROD_W'(ihl_q) << (HALF_W + 1))
					+ PROD_W'(ill_q);
				cr_q   <= (PROD_W'(xhh_q) << (2 * HALF_W)) + (PROD_W'(xhl_q) << HALF_W)
					+ (PROD_W'(xlh_q) << HALF_W) + PROD_W'(xll_q);
			end
			IT_TEST: begin
				nr_q <= diff_sh[VAL_W-1:0];
				ni_q <= xs_sh[VAL_W-1:0];
			end
			IT_ADD: begin
				z_re_q <= sat_add(nr_q, c_re_q);
				z_im_q <= sat_add(ni_q, c_im_q);
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d    = state_q;
		pop_ready  = 1'b0;
		done_valid = 1'b0;
		case (state_q)
			IT_IDLE: begin
				pop_ready = 1'b1;
				if (pop_valid) begin
					state_d = IT_MAG;
				end
			end
			IT_MAG: begin
				state_d = IT_MUL;
			end
			IT_MUL: begin
				state_d = IT_SUM;
			end
			IT_SUM: begin
				state_d = IT_TEST;
			end
			IT_TEST: begin
				if (fin) begin
					done_valid = 1'b1;
					if (done_ready) begin
						state_d = IT_IDLE;
					end
				end else begin
					state_d = IT_ADD;
				end
			end
			IT_ADD: begin
				state_d = IT_MAG;
			end
			default: begin
				state_d = IT_IDLE;
			end
		endcase
	end

endmodule

[rtl/mandelbrot_escape_time_top.sv]
// path: coordinate mapping (idle, multiply, sum, add states), the queue, then per escape
// test the magnitude, multiply, sum and test states plus an add state per z*z+c step in the
// iteration sequencer, then the output register; the sequencer takes one pixel at a time,
// with no new point until the last result is handed off; mapping overlaps iteration
// reset: asynchronous, clears the sequencers, the queue and the output beat, and loads
// the register defaults
module mandelbrot_escape_time_top import mbe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	mbe_pix_if.sink    pixel,
	mbe_depth_if.source result,
	mbe_cfg_if.sink    cfg
);

	cfg_t             cfg_regs_q;
	logic             push_valid, push_ready, pop_valid, pop_ready;
	point_t           push_data, pop_data;
	logic             done_valid, done_ready;
	logic [CNT_W-1:0] done_depth;
	logic             out_valid_q;
	logic [CNT_W-1:0] depth_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_regs_q.center_re    <= '0;
			cfg_regs_q.center_im    <= '0;
			cfg_regs_q.pixel_scale  <= '0;
			cfg_regs_q.max_iter     <= MAX_ITER_RST;
			cfg_regs_q.image_width  <= DIM_RST;
			cfg_regs_q.image_height <= DIM_RST;
			cfg_regs_q.escape_mode  <= ESC_CIRCLE;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_CENTER_RE:    cfg_regs_q.center_re    <= $signed(cfg.data);
				REG_CENTER_IM:    cfg_regs_q.center_im    <= $signed(cfg.data);
				REG_PIXEL_SCALE:  cfg_regs_q.pixel_scale  <= cfg.data[SCALE_W-1:0];
				REG_MAX_ITER:     cfg_regs_q.max_iter     <= cfg.data[CNT_W-1:0];
				REG_IMAGE_WIDTH:  cfg_regs_q.image_width  <= cfg.data[DIM_W-1:0];
				REG_IMAGE_HEIGHT: cfg_regs_q.image_height <= cfg.data[DIM_W-1:0];
				REG_ESCAPE_MODE:  cfg_regs_q.escape_mode  <= esc_mode_t'(cfg.data[0]);
				default: begin
				end
			endcase
		end
	end

	mbe_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_regs   (cfg_regs_q),
		.pixel      (pixel),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	mbe_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	mbe_iter u_iter (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_regs   (cfg_regs_q),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data),
		.done_valid (done_valid),
		.done_ready (done_ready),
		.done_depth (done_depth)
	);

	// output beat register lets the sequencer hand off one result while the sink stalls
	assign done_ready   = !out_valid_q || result.ready;
	assign result.valid = out_valid_q;
	assign result.depth = depth_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done_valid && done_ready) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_valid && done_ready) begin
			depth_q <= done_depth;
		end
	end

endmodule
